// File: hw/rtl/circular_deque_assert.svh
// Assertion macros for the circular deque RTL.
// Expects clk and arst_n in the scope of the using module.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CDQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CDQ_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define CDQ_ASSERT(lbl, prop, msg)
`define CDQ_NEVER(lbl, cond, msg)
`endif
`endif

// File: hw/rtl/cdq_pkg.sv
// Shared constants and types for the circular deque.
// No dependencies.
`default_nettype none
package cdq_pkg;
	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CAP_W  = 5;
	localparam int DATA_W = 32;
	localparam int KIND_W = 2;
	localparam int RES_W  = 72;
	localparam int ADDR_W = 3;
	localparam int PDATA_W = 32;

	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_PUSH_FRONT = 2'd0;
	localparam kind_t KIND_PUSH_BACK  = 2'd1;
	localparam kind_t KIND_POP_FRONT  = 2'd2;
	localparam kind_t KIND_POP_BACK   = 2'd3;

	// register word index within paddr
	localparam logic CAP_REG = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

	typedef struct packed {
		logic [CAP_W-1:0]  occupancy;
		logic              is_full;
		logic              is_empty;
		logic [DATA_W-1:0] rear_value;
		logic [DATA_W-1:0] front_value;
		logic              accepted;
	} res_t;
endpackage
`default_nettype wire

// File: hw/rtl/cdq_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/circular_deque.sv
// Circular deque top level: request register, index/count update, ring RAM, result register.
// Depends on cdq_pkg, cdq_ram and circular_deque_assert.svh.
`default_nettype none
`include "circular_deque_assert.svh"
// Double-ended queue of 32-bit values in a 16-entry ring. Each request is one of
// push front, push back, pop front or pop back (s_tuser) with its value in s_tdata.
// One request can be taken per cycle while the output is not stalled. A request
// sits in the request register, where indices and occupancy are updated and the
// ring RAM is written and read at the new front and rear. Its result then moves to
// the result register, which drives m_tdata, and waits there until m_tready; while
// it waits the request register and then the input stall. The ring RAM takes one
// write and two reads each cycle, so back-to-back requests never wait on each
// other. The result gives the success flag, the front and rear values after the
// operation (all ones when empty), empty, full and occupancy.
// Writing capacity_in_use (APB addresses 0 to 3) empties the deque; a capacity of 0
// acts as 1 and anything above 16 as 16.
module circular_deque (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [cdq_pkg::DATA_W-1:0]  s_tdata,   // push_value
	input  logic [cdq_pkg::KIND_W-1:0]  s_tuser,   // kind
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// accepted, front_value, rear_value, is_empty, is_full, occupancy
	output logic [cdq_pkg::RES_W-1:0]   m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cdq_pkg::ADDR_W-1:0]  paddr,
	input  logic [cdq_pkg::PDATA_W-1:0] pwdata,
	output logic [cdq_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import cdq_pkg::*;

	function automatic logic [IDX_W-1:0] slot_before(input logic [IDX_W-1:0] idx,
			input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] last;
		last = cap - 1'b1;
		if (idx == '0 || CAP_W'(idx) >= cap) begin
			return last[IDX_W-1:0];
		end
		return idx - 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] idx,
			input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] nx;
		nx = CAP_W'(idx) + 1'b1;
		if (nx >= cap) begin
			return '0;
		end
		return nx[IDX_W-1:0];
	endfunction

	logic              valid_s1;
	kind_t             kind_s1;
	logic [DATA_W-1:0] value_s1;

	logic              valid_s2;
	logic              ok_s2;
	logic              empty_s2;
	logic              full_s2;
	logic [CAP_W-1:0]  occ_s2;
	logic              byp_f_s2;
	logic              byp_r_s2;
	logic [DATA_W-1:0] value_s2;

	logic [CAP_W-1:0]  cap_q;
	logic [IDX_W-1:0]  front_q;
	logic [IDX_W-1:0]  back_q;
	logic [CAP_W-1:0]  entry_count_q;

	logic              adv;
	logic              cfg_we;
	logic [CAP_W-1:0]  cap_eff;
	logic [IDX_W-1:0]  f_cur;
	logic [IDX_W-1:0]  b_cur;
	logic [IDX_W-1:0]  f_nxt;
	logic [IDX_W-1:0]  b_nxt;
	logic [CAP_W-1:0]  cnt_nxt;
	logic              ok;
	logic              is_push;
	logic              full;
	logic              empty;
	logic              ram_we;
	logic [IDX_W-1:0]  waddr;
	logic [IDX_W-1:0]  rd_rear;
	logic [DATA_W-1:0] rdata_f;
	logic [DATA_W-1:0] rdata_r;
	res_t              res;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = (paddr[ADDR_W-1] == CAP_REG) ? PDATA_W'(cap_q) : '0;

	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = valid_s2;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (cap_q > CAP_W'(DEPTH)) begin
			cap_eff = CAP_W'(DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	always_comb begin
		f_cur   = (CAP_W'(front_q) >= cap_eff) ? '0 : front_q;
		b_cur   = (CAP_W'(back_q) >= cap_eff) ? '0 : back_q;
		full    = entry_count_q >= cap_eff;
		empty   = entry_count_q == '0;
		f_nxt   = f_cur;
		b_nxt   = b_cur;
		cnt_nxt = entry_count_q;
		ok      = 1'b0;
		is_push = 1'b0;
		waddr   = b_cur;
		unique case (kind_s1)
			KIND_PUSH_FRONT: begin
				is_push = 1'b1;
				if (!full) begin
					f_nxt   = slot_before(f_cur, cap_eff);
					waddr   = f_nxt;
					cnt_nxt = entry_count_q + 1'b1;
					ok      = 1'b1;
				end
			end
			KIND_PUSH_BACK: begin
				is_push = 1'b1;
				if (!full) begin
					waddr   = b_cur;
					b_nxt   = slot_after(b_cur, cap_eff);
					cnt_nxt = entry_count_q + 1'b1;
					ok      = 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (!empty) begin
					f_nxt   = slot_after(f_cur, cap_eff);
					cnt_nxt = entry_count_q - 1'b1;
					ok      = 1'b1;
				end
			end
			KIND_POP_BACK: begin
				if (!empty) begin
					b_nxt   = slot_before(b_cur, cap_eff);
					cnt_nxt = entry_count_q - 1'b1;
					ok      = 1'b1;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	assign ram_we  = valid_s1 && adv && ok && is_push;
	assign rd_rear = slot_before(b_nxt, cap_eff);

	cdq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ring (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (waddr),
		.wdata  (value_s1),
		.re     (adv),
		.raddr_a(f_nxt),
		.raddr_b(rd_rear),
		.rdata_a(rdata_f),
		.rdata_b(rdata_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1  <= s_tuser;
			value_s1 <= s_tdata;
		end
		if (adv && valid_s1) begin
			ok_s2    <= ok;
			empty_s2 <= cnt_nxt == '0;
			full_s2  <= cnt_nxt == cap_eff;
			occ_s2   <= cnt_nxt;
			// RAM reads the old word; forward the request's value on a hit
			byp_f_s2 <= ram_we && (waddr == f_nxt);
			byp_r_s2 <= ram_we && (waddr == rd_rear);
			value_s2 <= value_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q         <= CAP_RESET;
			front_q       <= '0;
			back_q        <= '0;
			entry_count_q <= '0;
		end else if (cfg_we) begin
			if (paddr[ADDR_W-1] == CAP_REG) begin
				cap_q         <= pwdata[CAP_W-1:0];
				front_q       <= '0;
				back_q        <= '0;
				entry_count_q <= '0;
			end
		end else if (valid_s1 && adv) begin
			front_q       <= f_nxt;
			back_q        <= b_nxt;
			entry_count_q <= cnt_nxt;
		end
	end

	always_comb begin
		res.accepted    = ok_s2;
		res.front_value = empty_s2 ? EMPTY_VALUE : (byp_f_s2 ? value_s2 : rdata_f);
		res.rear_value  = empty_s2 ? EMPTY_VALUE : (byp_r_s2 ? value_s2 : rdata_r);
		res.is_empty    = empty_s2;
		res.is_full     = full_s2;
		res.occupancy   = occ_s2;
	end

	assign m_tdata = res;

	`CDQ_NEVER(a_count_le_cap, entry_count_q > cap_eff, "occupancy above capacity")
	`CDQ_NEVER(a_idx_in_ring, (CAP_W'(front_q) >= cap_eff) || (CAP_W'(back_q) >= cap_eff), "index outside ring")
	`CDQ_ASSERT(a_ends_meet, (entry_count_q == '0 || entry_count_q == cap_eff) |-> (front_q == back_q), "front and back apart when empty or full")
	`CDQ_ASSERT(a_stall_holds, (valid_s2 && !m_tready && !cfg_we) |=> ($stable(entry_count_q) && $stable(front_q) && $stable(back_q)), "state moved during output stall")
endmodule
`default_nettype wire
